@@ rtl/core/ctcgd_pkg.sv @@
// shared types, widths, register codes and reset values of the greedy ctc decoder
`timescale 1ns / 1ps

package ctcgd_pkg;

   // default sizes
   localparam int MAX_STEPS_DEF   = 256;
   localparam int MAX_CLASSES_DEF = 8192;

   // fixed field widths
   localparam int PROB_W      = 16;
   localparam int LABELS_W    = 14;
   localparam int SHIFT_W     = 16;
   localparam int PPS_W       = 16;
   localparam int LABEL_IDX_W = 13;
   localparam int STEP_IDX_W  = 8;
   localparam int X_W         = 16;
   localparam int MEAN_W      = 16;
   localparam int COUNT_W     = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LABELS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_STEPS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETAIL_ENABLE = 2'd2;

   // register reset values
   localparam logic [LABELS_W-1:0] NUM_LABELS_RST    = 14'd6625;
   localparam logic [SHIFT_W-1:0]  SHIFT_STEPS_RST   = 16'd384;
   localparam logic                DETAIL_ENABLE_RST = 1'b1;

   // result kinds
   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_EMIT,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic take_word;
      logic finish_step;
      logic div_start;
      logic div_run;
      logic send_summary;
   } cmd_type;

   typedef struct packed {
      logic emit_char;
      logic line_end;
      logic out_free;
      logic div_done;
   } status_type;

endpackage

@@ rtl/core/ctcgd_div.sv @@
// restoring divider, one quotient bit per cycle while run is high
`timescale 1ns / 1ps

module ctcgd_div #(
   parameter int DW = 25,
   parameter int VW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          run,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW:0]   trial;
   logic          fits;

   // load on start, otherwise one shift and subtract step while run is high
   always_comb begin
      trial  = {rem_ff, quo_ff[DW-1]};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
      end else if (run && cnt_ff != '0) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? VW'(trial - {1'b0, dvs_ff}) : trial[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = cnt_ff == '0;

endmodule

@@ rtl/core/ctcgd_dp.sv @@
// datapath: running maximum, line totals, position multiply, mean division, result register
`timescale 1ns / 1ps

module ctcgd_dp #(
   parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF,
   parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ctcgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctcgd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [ctcgd_pkg::PROB_W-1:0]        req_class_prob,
   input  logic                                req_class_end,
   input  logic                                req_line_end,
   input  logic [ctcgd_pkg::PPS_W-1:0]         req_pixels_per_step,
   input  ctcgd_pkg::cmd_type                  cmd,
   output ctcgd_pkg::status_type               status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [ctcgd_pkg::LABEL_IDX_W-1:0]   rsp_label_index,
   output logic [ctcgd_pkg::STEP_IDX_W-1:0]    rsp_step_index,
   output logic [ctcgd_pkg::PROB_W-1:0]        rsp_char_score,
   output logic [ctcgd_pkg::X_W-1:0]           rsp_x_position,
   output logic [ctcgd_pkg::MEAN_W-1:0]        rsp_mean_score,
   output logic [ctcgd_pkg::COUNT_W-1:0]       rsp_char_count,
   output logic                                rsp_last
);

   localparam int CLW  = $clog2(MAX_CLASSES);
   localparam int STW  = $clog2(MAX_STEPS);
   localparam int CNW  = $clog2(MAX_STEPS + 1);
   localparam int SUMW = ctcgd_pkg::PROB_W + CNW;
   localparam int CMPW = (CLW > ctcgd_pkg::LABELS_W) ? CLW : ctcgd_pkg::LABELS_W;
   localparam int EW   = ((STW + 8 > ctcgd_pkg::SHIFT_W) ? STW + 8 : ctcgd_pkg::SHIFT_W) + 1;
   localparam int PW   = EW - 1 + ctcgd_pkg::PPS_W;

   // configuration registers
   logic [ctcgd_pkg::LABELS_W-1:0] num_labels_ff;
   logic [ctcgd_pkg::SHIFT_W-1:0]  shift_steps_ff;
   logic                           detail_enable_ff;

   // decoding state
   logic [CLW-1:0]              class_cnt_ff, class_cnt_in;
   logic [STW-1:0]              step_ff, step_in;
   logic [ctcgd_pkg::PROB_W-1:0] best_prob_ff, best_prob_in;
   logic [CLW-1:0]              best_idx_ff, best_idx_in;
   logic [CLW-1:0]              prev_idx_ff, prev_idx_in;
   logic [SUMW-1:0]             sum_ff, sum_in;
   logic [CNW-1:0]              count_ff, count_in;
   logic                        line_end_ff, line_end_in;
   logic [ctcgd_pkg::PPS_W-1:0] pps_ff, pps_in;
   logic [PW-1:0]               prod_ff;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff;
   logic [ctcgd_pkg::LABEL_IDX_W-1:0]   rsp_label_ff;
   logic [ctcgd_pkg::STEP_IDX_W-1:0]    rsp_step_ff;
   logic [ctcgd_pkg::PROB_W-1:0]        rsp_score_ff;
   logic [ctcgd_pkg::X_W-1:0]           rsp_x_ff;
   logic [ctcgd_pkg::MEAN_W-1:0]        rsp_mean_ff;
   logic [ctcgd_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic                                rsp_last_ff;

   logic                  emit_char;
   logic                  out_free;
   logic                  load_char;
   logic signed [EW-1:0]  diff;
   logic [EW-2:0]         diff_pos;
   logic [PW:0]           rnd;
   logic [PW-16:0]        x_raw;
   logic [ctcgd_pkg::X_W-1:0]    x_sat;
   logic [SUMW-1:0]       quotient;
   logic                  div_done;
   logic [ctcgd_pkg::MEAN_W-1:0] mean;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_labels_ff    <= ctcgd_pkg::NUM_LABELS_RST;
         shift_steps_ff   <= ctcgd_pkg::SHIFT_STEPS_RST;
         detail_enable_ff <= ctcgd_pkg::DETAIL_ENABLE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            ctcgd_pkg::CSR_NUM_LABELS: begin
               num_labels_ff <= csr_wdata[ctcgd_pkg::LABELS_W-1:0];
            end
            ctcgd_pkg::CSR_SHIFT_STEPS: begin
               shift_steps_ff <= csr_wdata[ctcgd_pkg::SHIFT_W-1:0];
            end
            ctcgd_pkg::CSR_DETAIL_ENABLE: begin
               detail_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // character decision on the finished step
   assign emit_char = best_idx_ff != '0 && best_idx_ff != prev_idx_ff
                      && CMPW'(best_idx_ff) < CMPW'(num_labels_ff)
                      && count_ff < CNW'(MAX_STEPS);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_char = cmd.finish_step && emit_char;

   // left edge: (step * 256 - shift) * pixels, clamped at zero
   always_comb begin
      diff     = $signed({1'b0, (EW-1)'({step_ff, 8'd0})})
                 - $signed({1'b0, (EW-1)'(shift_steps_ff)});
      diff_pos = (diff > 0) ? diff[EW-2:0] : '0;
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(diff_pos * pps_ff);
   end

   // rounding and saturation of the product
   always_comb begin
      rnd   = (PW+1)'(prod_ff) + (PW+1)'(32768);
      x_raw = rnd[PW:16];
      x_sat = (32'(x_raw) > 32'd65535) ? 16'hffff : ctcgd_pkg::X_W'(x_raw);
   end

   // mean score over the line
   ctcgd_div #(
      .DW (SUMW),
      .VW (CNW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .run      (cmd.div_run),
      .dividend (sum_ff + SUMW'(count_ff >> 1)),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      if (count_ff == '0) begin
         mean = '0;
      end else if (32'(quotient) > 32'd65535) begin
         mean = 16'hffff;
      end else begin
         mean = ctcgd_pkg::MEAN_W'(quotient);
      end
   end

   // next values of the decoding state
   always_comb begin
      class_cnt_in = class_cnt_ff;
      best_prob_in = best_prob_ff;
      best_idx_in  = best_idx_ff;
      prev_idx_in  = prev_idx_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      line_end_in  = line_end_ff;
      pps_in       = pps_ff;
      if (cmd.take_word) begin
         if (class_cnt_ff == '0 || req_class_prob > best_prob_ff) begin
            best_prob_in = req_class_prob;
            best_idx_in  = class_cnt_ff;
         end
         if (req_class_end) begin
            class_cnt_in = '0;
            line_end_in  = req_line_end;
            pps_in       = req_pixels_per_step;
         end else if (class_cnt_ff < CLW'(MAX_CLASSES - 1)) begin
            class_cnt_in = class_cnt_ff + 1'b1;
         end
      end
      if (cmd.finish_step) begin
         if (emit_char) begin
            sum_in   = sum_ff + SUMW'(best_prob_ff);
            count_in = count_ff + 1'b1;
         end
         prev_idx_in = best_idx_ff;
         if (!line_end_ff && step_ff < STW'(MAX_STEPS - 1)) begin
            step_in = step_ff + 1'b1;
         end
      end
      if (cmd.send_summary) begin
         step_in     = '0;
         prev_idx_in = '0;
         sum_in      = '0;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_cnt_ff <= '0;
         best_prob_ff <= '0;
         best_idx_ff  <= '0;
         prev_idx_ff  <= '0;
         step_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         class_cnt_ff <= class_cnt_in;
         best_prob_ff <= best_prob_in;
         best_idx_ff  <= best_idx_in;
         prev_idx_ff  <= prev_idx_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      line_end_ff <= line_end_in;
      pps_ff      <= pps_in;
   end

   // result word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_char || cmd.send_summary) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (load_char) begin
         rsp_kind_ff  <= ctcgd_pkg::KIND_CHAR;
         rsp_label_ff <= ctcgd_pkg::LABEL_IDX_W'(best_idx_ff - 1'b1);
         rsp_step_ff  <= ctcgd_pkg::STEP_IDX_W'(step_ff);
         rsp_score_ff <= detail_enable_ff ? best_prob_ff : '0;
         rsp_x_ff     <= detail_enable_ff ? x_sat : '0;
         rsp_mean_ff  <= '0;
         rsp_count_ff <= '0;
         rsp_last_ff  <= 1'b0;
      end else if (cmd.send_summary) begin
         rsp_kind_ff  <= ctcgd_pkg::KIND_SUMMARY;
         rsp_label_ff <= '0;
         rsp_step_ff  <= '0;
         rsp_score_ff <= '0;
         rsp_x_ff     <= '0;
         rsp_mean_ff  <= mean;
         rsp_count_ff <= ctcgd_pkg::COUNT_W'(count_ff);
         rsp_last_ff  <= 1'b1;
      end
   end

   assign status.emit_char = emit_char;
   assign status.line_end  = line_end_ff;
   assign status.out_free  = out_free;
   assign status.div_done  = div_done;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_label_index = rsp_label_ff;
   assign rsp_step_index  = rsp_step_ff;
   assign rsp_char_score  = rsp_score_ff;
   assign rsp_x_position  = rsp_x_ff;
   assign rsp_mean_score  = rsp_mean_ff;
   assign rsp_char_count  = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // character count never passes the per-line limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(MAX_STEPS))
      else $error("character count beyond limit");

   // a step-end word restarts the class counter
   a_class_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.take_word && req_class_end |=> class_cnt_ff == '0)
      else $error("class counter not cleared at step end");

   // a summary clears the line totals and presents a summary word
   a_summary_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.send_summary |=> rsp_valid_ff && rsp_kind_ff == ctcgd_pkg::KIND_SUMMARY
                           && count_ff == '0 && step_ff == '0 && sum_ff == '0)
      else $error("summary did not clear line state");

   // an emitted character lands in the result register
   a_char_load: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_step && emit_char |=> rsp_valid_ff
                                       && rsp_kind_ff == ctcgd_pkg::KIND_CHAR)
      else $error("character word not loaded");
`endif

endmodule

@@ rtl/core/ctcgd_ctrl.sv @@
// controller: sequences word intake, step finish, division and summary
`timescale 1ns / 1ps

module ctcgd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_class_end,
   output logic                  req_ready,
   input  ctcgd_pkg::status_type status,
   output ctcgd_pkg::cmd_type    cmd
);

   ctcgd_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctcgd_pkg::ST_IDLE: begin
            if (req_valid && req_class_end) begin
               state_in = ctcgd_pkg::ST_CALC;
            end
         end
         ctcgd_pkg::ST_CALC: begin
            state_in = ctcgd_pkg::ST_EMIT;
         end
         ctcgd_pkg::ST_EMIT: begin
            if (!status.emit_char || status.out_free) begin
               state_in = status.line_end ? ctcgd_pkg::ST_DIV_INIT : ctcgd_pkg::ST_IDLE;
            end
         end
         ctcgd_pkg::ST_DIV_INIT: begin
            state_in = ctcgd_pkg::ST_DIV_RUN;
         end
         ctcgd_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ctcgd_pkg::ST_SUMMARY;
            end
         end
         ctcgd_pkg::ST_SUMMARY: begin
            if (status.out_free) begin
               state_in = ctcgd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctcgd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctcgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ctcgd_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_word = req_valid;
         end
         ctcgd_pkg::ST_EMIT: begin
            cmd.finish_step = !status.emit_char || status.out_free;
         end
         ctcgd_pkg::ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
         end
         ctcgd_pkg::ST_DIV_RUN: begin
            cmd.div_run = 1'b1;
         end
         ctcgd_pkg::ST_SUMMARY: begin
            cmd.send_summary = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/core/ctc_greedy_decoder_unit.sv @@
// top level of the greedy ctc decoder: controller and datapath
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_ready      class_prob, class_end, line_end,
//                                                    pixels_per_step
//   rsp       out         rsp_valid / rsp_ready      kind, label_index, step_index,
//                                                    char_score, x_position, mean_score,
//                                                    char_count, last
//   csr       in          csr_write_en               csr_index, csr_wdata
//
// a word that does not end a time step is taken back to back with the next.
// a step-end word goes through three steps: intake, position multiply, step finish.
// a line end then runs the one-bit-per-cycle divider for the mean score, through the
// division start and run states, before the summary word is loaded.
// results wait in a single output register; words keep flowing while it is full and
// only a step finish that must emit, or the summary, waits for rsp_ready. synchronous
// reset clears decoding state but line_end_ff, pps_ff; restores register defaults.
`timescale 1ns / 1ps

module ctc_greedy_decoder_unit #(
   parameter int MAX_STEPS   = ctcgd_pkg::MAX_STEPS_DEF,
   parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ctcgd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctcgd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ctcgd_pkg::PROB_W-1:0]        req_class_prob,
   input  logic                                req_class_end,
   input  logic                                req_line_end,
   input  logic [ctcgd_pkg::PPS_W-1:0]         req_pixels_per_step,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [ctcgd_pkg::LABEL_IDX_W-1:0]   rsp_label_index,
   output logic [ctcgd_pkg::STEP_IDX_W-1:0]    rsp_step_index,
   output logic [ctcgd_pkg::PROB_W-1:0]        rsp_char_score,
   output logic [ctcgd_pkg::X_W-1:0]           rsp_x_position,
   output logic [ctcgd_pkg::MEAN_W-1:0]        rsp_mean_score,
   output logic [ctcgd_pkg::COUNT_W-1:0]       rsp_char_count,
   output logic                                rsp_last
);

   ctcgd_pkg::cmd_type    cmd;
   ctcgd_pkg::status_type status;

   // sequencing
   ctcgd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_class_end (req_class_end),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // arithmetic and storage
   ctcgd_dp #(
      .MAX_STEPS   (MAX_STEPS),
      .MAX_CLASSES (MAX_CLASSES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_class_prob      (req_class_prob),
      .req_class_end       (req_class_end),
      .req_line_end        (req_line_end),
      .req_pixels_per_step (req_pixels_per_step),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_label_index     (rsp_label_index),
      .rsp_step_index      (rsp_step_index),
      .rsp_char_score      (rsp_char_score),
      .rsp_x_position      (rsp_x_position),
      .rsp_mean_score      (rsp_mean_score),
      .rsp_char_count      (rsp_char_count),
      .rsp_last            (rsp_last)
   );

endmodule
